[src/bole_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Action, status and edit codes, and the command/status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VAL_W        = 32;
	localparam int ACT_W        = 3;
	localparam int ST_W         = 3;
	localparam int CNT_OUT_W    = 5;
	localparam int TDATA_W      = 40;
	localparam int TUSER_W      = 3;

	// requested actions
	localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_AFTER = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd5;

	// result status
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [ST_W-1:0] ST_SHORT   = 3'd2;
	localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

	// datapath edits on the cell row
	localparam logic [2:0] ED_NONE      = 3'd0;
	localparam logic [2:0] ED_INS_FRONT = 3'd1;
	localparam logic [2:0] ED_INS_BACK  = 3'd2;
	localparam logic [2:0] ED_DEL_FRONT = 3'd3;
	localparam logic [2:0] ED_DEL_BACK  = 3'd4;
	localparam logic [2:0] ED_DEL_AFTER = 3'd5;
	localparam logic [2:0] ED_ROTATE    = 3'd6;

	typedef struct packed {
		logic            load;
		logic            compare;
		logic [2:0]      edit;
		logic            rd_clr;
		logic            emit;
		logic [ST_W-1:0] emit_status;
		logic            emit_front;
		logic            emit_last;
	} bole_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic short_list;
		logic hit;
		logic rd_last;
		logic out_free;
	} bole_sts_t;

endpackage
`default_nettype wire

[src/bounded_ordered_list_engine_top.sv]
`default_nettype none
// Edits: result word registered from the execute state (via a compare state for delete after).
// Read-out: a setup step, then one word per cycle per held element while the output is free.
// One action in flight; next word accepted once the current action has issued
// its last result.
// Reset clears the element count and control; stored values are not cleared.
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of signed values held in shifting cells, with front/back
// insert and delete, delete after match, and full read-out.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [31:0]                       s_tdata,  // [31:0] operand_value
	input  wire  [bole_pkg::TUSER_W-1:0]      s_tuser,  // [2:0] action
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [bole_pkg::TDATA_W-1:0]      m_tdata,  // [31:0] element_value, [36:32] element_count
	output logic [bole_pkg::TUSER_W-1:0]      m_tuser,  // [2:0] status
	output logic                              m_tlast   // last_result
);
	import bole_pkg::*;

	bole_cmd_t             cmd;
	bole_sts_t             sts;
	logic [VAL_W-1:0]      out_value;
	logic [CNT_OUT_W-1:0]  out_count;
	logic [ST_W-1:0]       out_status;

	bole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser[ACT_W-1:0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	bole_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operand_value (s_tdata),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_status    (out_status),
		.out_value     (out_value),
		.out_count     (out_count),
		.out_last      (m_tlast)
	);

	assign m_tdata = {{(TDATA_W - VAL_W - CNT_OUT_W){1'b0}}, out_count, out_value};
	assign m_tuser = out_status;

endmodule
`default_nettype wire

[src/bole_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered list datapath
// Row of value cells with parallel shift, match compare, read-out counter
// and the output word register.
// ----------------------------------------------------------------------------
module bole_dp #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire bole_pkg::bole_cmd_t             cmd,
	output bole_pkg::bole_sts_t                  sts,
	input  wire  [bole_pkg::VAL_W-1:0]           operand_value,
	input  wire                                  out_ready,
	output logic                                 out_valid,
	output logic [bole_pkg::ST_W-1:0]            out_status,
	output logic [bole_pkg::VAL_W-1:0]           out_value,
	output logic [bole_pkg::CNT_OUT_W-1:0]       out_count,
	output logic                                 out_last
);
	import bole_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [VAL_W-1:0] cells_q [CAPACITY];
	logic [VAL_W-1:0] cells_d [CAPACITY];
	logic [VAL_W-1:0] value_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [CW-1:0]    rd_q;
	logic [CAPACITY-1:0] match_q;
	logic [CAPACITY-1:0] match_d;
	logic [CAPACITY-1:0] after;
	logic             out_valid_q;
	logic             out_free;

	// cells strictly behind the first match
	assign after = ~(match_q ^ (match_q - 1'b1));

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_d[i] = (cells_q[i] == value_q) && (CW'(i + 1) < count_q);
		end
	end

	always_comb begin
		cells_d = cells_q;
		count_d = count_q;
		unique case (cmd.edit)
			ED_INS_FRONT: begin
				for (int i = 1; i < CAPACITY; i++) begin
					cells_d[i] = cells_q[i - 1];
				end
				cells_d[0] = value_q;
				count_d    = count_q + 1'b1;
			end
			ED_INS_BACK: begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (CW'(i) == count_q) begin
						cells_d[i] = value_q;
					end
				end
				count_d = count_q + 1'b1;
			end
			ED_DEL_FRONT: begin
				for (int i = 0; i < CAPACITY; i++) begin
					cells_d[i] = cells_q[(i + 1) % CAPACITY];
				end
				count_d = count_q - 1'b1;
			end
			ED_DEL_BACK: begin
				count_d = count_q - 1'b1;
			end
			ED_DEL_AFTER: begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (after[i]) begin
						cells_d[i] = cells_q[(i + 1) % CAPACITY];
					end
				end
				count_d = count_q - 1'b1;
			end
			ED_ROTATE: begin
				// advance by one, front wraps to the back of the held run
				for (int i = 0; i < CAPACITY; i++) begin
					if (CW'(i + 1) == count_q) begin
						cells_d[i] = cells_q[0];
					end else begin
						cells_d[i] = cells_q[(i + 1) % CAPACITY];
					end
				end
			end
			default: begin
				cells_d = cells_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cells_q <= cells_d;
		if (cmd.load) begin
			value_q <= operand_value;
		end
		if (cmd.compare) begin
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.rd_clr) begin
				rd_q <= '0;
			end else if (cmd.edit == ED_ROTATE) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status <= cmd.emit_status;
			out_value  <= cmd.emit_front ? cells_q[0] : '0;
			out_count  <= CNT_OUT_W'(count_d);
			out_last   <= cmd.emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == CW'(CAPACITY));
	assign sts.short_list = (count_q < CW'(2));
	assign sts.hit        = |match_q;
	assign sts.rd_last    = ((rd_q + 1'b1) == count_q);
	assign sts.out_free   = out_free;

endmodule
`default_nettype wire

[src/bole_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered list controller
// Sequences one action at a time: latch, optional match compare, edit or
// read-out, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module bole_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [bole_pkg::ACT_W-1:0]      action,
	input  wire bole_pkg::bole_sts_t        sts,
	output bole_pkg::bole_cmd_t             cmd
);
	import bole_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_READ = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [ACT_W-1:0] act_q;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					state_d = (action == ACT_DEL_AFTER) ? S_CMP : S_EXEC;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.emit_last = 1'b1;
					cmd.emit      = 1'b1;
					state_d       = S_IDLE;
					case (act_q) inside
						ACT_INS_FRONT, ACT_INS_BACK: begin
							if (sts.full) begin
								cmd.emit_status = ST_FULL;
							end else begin
								cmd.edit = (act_q == ACT_INS_FRONT) ? ED_INS_FRONT : ED_INS_BACK;
							end
						end
						ACT_DEL_FRONT, ACT_DEL_BACK: begin
							if (sts.empty) begin
								cmd.emit_status = ST_EMPTY;
							end else begin
								cmd.edit = (act_q == ACT_DEL_FRONT) ? ED_DEL_FRONT : ED_DEL_BACK;
							end
						end
						ACT_DEL_AFTER: begin
							if (sts.short_list) begin
								cmd.emit_status = ST_SHORT;
							end else if (!sts.hit) begin
								cmd.emit_status = ST_MISSING;
							end else begin
								cmd.edit = ED_DEL_AFTER;
							end
						end
						ACT_READ: begin
							if (sts.empty) begin
								cmd.emit_status = ST_EMPTY;
							end else begin
								// no word yet, start the walk
								cmd.emit      = 1'b0;
								cmd.emit_last = 1'b0;
								cmd.rd_clr    = 1'b1;
								state_d       = S_READ;
							end
						end
						default: begin
							cmd.emit_status = ST_OK;
						end
					endcase
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_front = 1'b1;
					cmd.emit_last  = sts.rd_last;
					cmd.edit       = ED_ROTATE;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
		end
	end

endmodule
`default_nettype wire

[test/bole_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// List engine result checker
// Watches both stream channels of the list engine, keeps its own copy of the
// list, works out the words each accepted action must produce and compares
// every returned word against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module bole_checker #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	input  wire                           s_tready,
	input  wire  [31:0]                   s_tdata,  // [31:0] operand_value
	input  wire  [bole_pkg::TUSER_W-1:0]  s_tuser,  // [2:0] action
	input  wire                           m_tvalid,
	input  wire                           m_tready,
	input  wire  [bole_pkg::TDATA_W-1:0]  m_tdata,  // [31:0] element_value, [36:32] element_count
	input  wire  [bole_pkg::TUSER_W-1:0]  m_tuser,  // [2:0] status
	input  wire                           m_tlast,  // last_result
	output int                            fail_count,
	output int                            words_pending
);
	import bole_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [VAL_W-1:0]     value;
		logic [CNT_OUT_W-1:0] count;
		logic                 last;
	} list_word_t;

	logic [VAL_W-1:0] list_cells [$];
	list_word_t       expected_words [$];
	int               reported;

	initial begin
		fail_count    = 0;
		words_pending = 0;
		reported      = 0;
	end

	task automatic queue_word(input logic [ST_W-1:0] status, input logic [VAL_W-1:0] value,
			input logic last);
		list_word_t w;
		w.status = status;
		w.value  = value;
		w.count  = CNT_OUT_W'(list_cells.size());
		w.last   = last;
		expected_words.push_back(w);
	endtask

	task automatic predict_list_action(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
		logic [ST_W-1:0] st;
		int              hit;
		st  = ST_OK;
		hit = -1;
		case (act)
			ACT_INS_FRONT: begin
				if (list_cells.size() >= CAPACITY)
					st = ST_FULL;
				else
					list_cells.push_front(val);
			end
			ACT_INS_BACK: begin
				if (list_cells.size() >= CAPACITY)
					st = ST_FULL;
				else
					list_cells.push_back(val);
			end
			ACT_DEL_FRONT: begin
				if (list_cells.size() == 0)
					st = ST_EMPTY;
				else
					void'(list_cells.pop_front());
			end
			ACT_DEL_BACK: begin
				if (list_cells.size() == 0)
					st = ST_EMPTY;
				else
					void'(list_cells.pop_back());
			end
			ACT_DEL_AFTER: begin
				if (list_cells.size() < 2) begin
					st = ST_SHORT;
				end else begin
					// only the first match counts
					for (int i = 0; i < list_cells.size(); i++) begin
						if (hit < 0 && list_cells[i] == val)
							hit = i;
					end
					if (hit < 0 || hit + 1 >= list_cells.size())
						st = ST_MISSING;
					else
						list_cells.delete(hit + 1);
				end
			end
			ACT_READ: begin
				if (list_cells.size() == 0) begin
					queue_word(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_cells.size(); i++)
						queue_word(ST_OK, list_cells[i], i + 1 == list_cells.size());
				end
			end
			default: begin
			end
		endcase
		if (act != ACT_READ)
			queue_word(st, '0, 1'b1);
	endtask

	task automatic check_word(input list_word_t got);
		list_word_t want;
		if (expected_words.size() == 0) begin
			fail_count++;
			if (reported < 10)
				$display("checker: unexpected word status %0d value %h count %0d last %0d",
					got.status, got.value, got.count, got.last);
			reported++;
		end else begin
			want = expected_words.pop_front();
			if (got.status !== want.status || got.value !== want.value ||
					got.count !== want.count || got.last !== want.last) begin
				fail_count++;
				if (reported < 10)
					$display({"checker: mismatch expected status %0d value %h count %0d last %0d,",
						" got status %0d value %h count %0d last %0d"},
						want.status, want.value, want.count, want.last,
						got.status, got.value, got.count, got.last);
				reported++;
			end
		end
	endtask

	always @(posedge clk) begin : watch
		list_word_t seen;
		if (arst_n) begin
			// compare before predicting: a new action never answers in its own cycle
			if (m_tvalid && m_tready) begin
				seen.status = m_tuser;
				seen.value  = m_tdata[31:0];
				seen.count  = m_tdata[36:32];
				seen.last   = m_tlast;
				check_word(seen);
			end
			if (s_tvalid && s_tready)
				predict_list_action(s_tuser, s_tdata);
			words_pending <= expected_words.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// List engine testbench
// Drives directed and random list actions into the engine under four idle
// and stall patterns, lets the checker compare every result word, and
// reports the verdict once all outstanding words have come back.
// ----------------------------------------------------------------------------
module tb_top;
	import bole_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_WORDS = 92;

	// codes the engine does not use; they must leave the list alone
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic [31:0]          s_tdata;
	logic [TUSER_W-1:0]   s_tuser;
	logic                 m_tready;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [TDATA_W-1:0]   m_tdata;
	wire  [TUSER_W-1:0]   m_tuser;
	wire                  m_tlast;

	int                   fail_count;
	int                   words_pending;
	int                   src_idle_pct   = 0;
	int                   sink_stall_pct = 0;
	int                   fill_estimate  = 0;
	bit                   growing        = 1'b1;
	logic [VAL_W-1:0]     value_pool [8];

	bounded_ordered_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bole_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic send_word(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= val;
		// hold the word until the engine takes it
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return value_pool[$urandom_range(0, 7)];
		else if (r < 9)
			return $urandom;
		else
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	task automatic send_random_word();
		int               r;
		logic [ACT_W-1:0] act;
		r = $urandom_range(0, 99);
		if (growing) begin
			if (r < 33)      act = ACT_INS_FRONT;
			else if (r < 65) act = ACT_INS_BACK;
			else if (r < 75) act = ACT_READ;
			else if (r < 85) act = ACT_DEL_AFTER;
			else if (r < 90) act = ACT_DEL_FRONT;
			else if (r < 95) act = ACT_DEL_BACK;
			else             act = r[0] ? ACT_SPARE_6 : ACT_SPARE_7;
		end else begin
			if (r < 8)       act = ACT_INS_FRONT;
			else if (r < 15) act = ACT_INS_BACK;
			else if (r < 25) act = ACT_READ;
			else if (r < 45) act = ACT_DEL_AFTER;
			else if (r < 70) act = ACT_DEL_FRONT;
			else if (r < 95) act = ACT_DEL_BACK;
			else             act = r[0] ? ACT_SPARE_6 : ACT_SPARE_7;
		end
		// rough fill level only steers the mix between filling and draining
		if ((act == ACT_INS_FRONT || act == ACT_INS_BACK) && fill_estimate < CAPACITY)
			fill_estimate++;
		if ((act == ACT_DEL_FRONT || act == ACT_DEL_BACK) && fill_estimate > 0)
			fill_estimate--;
		if (fill_estimate >= CAPACITY && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		if (fill_estimate == 0)
			growing = 1'b1;
		send_word(act, pick_value());
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		arst_n   <= 1'b0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_word(ACT_READ,      32'h0);
		send_word(ACT_DEL_FRONT, 32'h0);
		send_word(ACT_DEL_BACK,  32'h0);
		send_word(ACT_DEL_AFTER, 32'h0);
		// one element: too short to delete after
		send_word(ACT_INS_FRONT, 32'h8000_0000);
		send_word(ACT_DEL_AFTER, 32'h8000_0000);
		send_word(ACT_INS_BACK,  32'h7fff_ffff);
		send_word(ACT_INS_FRONT, 32'h0);
		send_word(ACT_READ,      32'hffff_ffff);
		// match at the back, then no match at all
		send_word(ACT_DEL_AFTER, 32'h7fff_ffff);
		send_word(ACT_DEL_AFTER, 32'h0000_0005);
		// duplicate value: only the first match removes its successor
		send_word(ACT_INS_BACK,  32'h0);
		send_word(ACT_DEL_AFTER, 32'h0);
		send_word(ACT_SPARE_6,   32'hffff_ffff);
		send_word(ACT_SPARE_7,   32'h5555_aaaa);
		send_word(ACT_READ,      32'h0);
		send_word(ACT_DEL_BACK,  32'h0);
		send_word(ACT_DEL_FRONT, 32'h0);
		send_word(ACT_DEL_FRONT, 32'h0);
		send_word(ACT_READ,      32'h0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			repeat (RANDOM_WORDS / 4) send_random_word();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
src/bole_pkg.sv
src/bole_dp.sv
src/bole_ctrl.sv
src/bounded_ordered_list_engine_top.sv
test/bole_checker.sv
test/tb_top.sv
